@@ rtl/bbm_pkg.sv @@
// ----------------------------------------------------------------------------
// bbm_pkg
// Shared widths, types and constants for the billboard matrix pipeline.
// ----------------------------------------------------------------------------
package bbm_pkg;

	localparam int COMP_W     = 32;
	localparam int VEC_W      = 3 * COMP_W;
	localparam int ITEM_W     = 4 * VEC_W;
	localparam int THR_W      = 17;
	localparam logic [THR_W-1:0] THR_RESET = 17'd7;

	// scaling before the length: largest magnitude gets its leading one here
	localparam int NORM_MSB   = 29;
	localparam int SCALED_W   = NORM_MSB + 1;
	localparam int ROOT_W     = SCALED_W + 1;

	// three components, index 0 is x
	typedef logic [2:0][COMP_W-1:0] trip_t;

endpackage

@@ rtl/bbm_norm.sv @@
// ----------------------------------------------------------------------------
// bbm_norm
// Pipelined vector normalisation: common scaling, sum of squares, one root
// bit per stage, then one quotient bit per stage for the three lanes.
// ----------------------------------------------------------------------------
module bbm_norm
	import bbm_pkg::*;
#(
	parameter int IN_W      = 33,
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [2:0][IN_W-1:0] in_vec,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output trip_t             out_vec,
	output logic [SIDE_W-1:0] out_side
);

	localparam int PW     = $clog2(IN_W);
	localparam int SQ_W   = 2 * SCALED_W;
	localparam int L2_W   = SQ_W + 2;
	localparam int SQ_N   = L2_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int QW     = FRAC_BITS + 1;
	localparam int NUM_W  = SCALED_W + FRAC_BITS + 1;

	function automatic logic [PW-1:0] lead_pos(input logic [IN_W-1:0] v);
		logic [PW-1:0] p;
		p = '0;
		for (int b = 0; b < IN_W; b++) begin
			if (v[b]) p = PW'(b);
		end
		return p;
	endfunction

	// stage 1: magnitudes, signs and the largest magnitude
	logic [2:0][IN_W-1:0] mag_c;
	logic [IN_W-1:0]      max_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
		end
		max_c = mag_c[0];
		if (mag_c[1] > max_c) max_c = mag_c[1];
		if (mag_c[2] > max_c) max_c = mag_c[2];
	end

	logic                 vld_s1, zero_s1;
	logic [2:0]           ng_s1;
	logic [2:0][IN_W-1:0] m_s1;
	logic [IN_W-1:0]      mx_s1;
	logic [SIDE_W-1:0]    side_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) ng_s1[i] <= in_vec[i][IN_W-1];
			m_s1    <= mag_c;
			mx_s1   <= max_c;
			zero_s1 <= (max_c == '0);
			side_s1 <= in_side;
		end
	end

	// stage 2: leading one of the largest magnitude
	logic                 vld_s2, zero_s2;
	logic [2:0]           ng_s2;
	logic [2:0][IN_W-1:0] m_s2;
	logic [PW-1:0]        p_s2;
	logic [SIDE_W-1:0]    side_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ng_s2   <= ng_s1;
			m_s2    <= m_s1;
			p_s2    <= lead_pos(mx_s1);
			zero_s2 <= zero_s1;
			side_s2 <= side_s1;
		end
	end

	// stage 3: common shift so the largest lands in [2^29, 2^30)
	logic [2:0][SCALED_W-1:0] sh_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (p_s2 >= PW'(NORM_MSB)) begin
				sh_c[i] = SCALED_W'(m_s2[i] >> (p_s2 - PW'(NORM_MSB)));
			end else begin
				sh_c[i] = m_s2[i][SCALED_W-1:0] << (PW'(NORM_MSB) - p_s2);
			end
		end
	end

	logic                     vld_s3, zero_s3;
	logic [2:0]               ng_s3;
	logic [2:0][SCALED_W-1:0] s_s3;
	logic [SIDE_W-1:0]        side_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ng_s3   <= ng_s2;
			s_s3    <= sh_c;
			zero_s3 <= zero_s2;
			side_s3 <= side_s2;
		end
	end

	// stage 4: squares
	logic                     vld_s4, zero_s4;
	logic [2:0]               ng_s4;
	logic [2:0][SCALED_W-1:0] s_s4;
	logic [2:0][SQ_W-1:0]     sq_s4;
	logic [SIDE_W-1:0]        side_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= SQ_W'(s_s3[i]) * SQ_W'(s_s3[i]);
			end
			ng_s4   <= ng_s3;
			s_s4    <= s_s3;
			zero_s4 <= zero_s3;
			side_s4 <= side_s3;
		end
	end

	// stage 5: square root, entry 0 takes the sum, each later entry one root bit
	logic                     vld_s5  [SQ_N+1];
	logic                     zero_s5 [SQ_N+1];
	logic [2:0]               ng_s5   [SQ_N+1];
	logic [2:0][SCALED_W-1:0] s_s5    [SQ_N+1];
	logic [SIDE_W-1:0]        side_s5 [SQ_N+1];
	logic [L2_W-1:0]          rad_s5  [SQ_N+1];
	logic [REM_W-1:0]         rem_s5  [SQ_N+1];
	logic [ROOT_W-1:0]        root_s5 [SQ_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5[0] <= 1'b0;
		end else if (en) begin
			vld_s5[0] <= vld_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s5[0]  <= L2_W'(sq_s4[0]) + L2_W'(sq_s4[1]) + L2_W'(sq_s4[2]);
			rem_s5[0]  <= '0;
			root_s5[0] <= '0;
			ng_s5[0]   <= ng_s4;
			s_s5[0]    <= s_s4;
			zero_s5[0] <= zero_s4;
			side_s5[0] <= side_s4;
		end
	end

	for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
		logic [REM_W+1:0] t_c, trial_c;
		always_comb begin
			t_c     = {rem_s5[k-1], rad_s5[k-1][L2_W-1 -: 2]};
			trial_c = (REM_W+2)'({root_s5[k-1], 2'b01});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s5[k] <= 1'b0;
			end else if (en) begin
				vld_s5[k] <= vld_s5[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (t_c >= trial_c) begin
					rem_s5[k]  <= REM_W'(t_c - trial_c);
					root_s5[k] <= {root_s5[k-1][ROOT_W-2:0], 1'b1};
				end else begin
					rem_s5[k]  <= REM_W'(t_c);
					root_s5[k] <= {root_s5[k-1][ROOT_W-2:0], 1'b0};
				end
				rad_s5[k]  <= rad_s5[k-1] << 2;
				ng_s5[k]   <= ng_s5[k-1];
				s_s5[k]    <= s_s5[k-1];
				zero_s5[k] <= zero_s5[k-1];
				side_s5[k] <= side_s5[k-1];
			end
		end
	end

	// stage 6: division, entry 0 forms the rounded numerators
	logic                   vld_s6  [QW+1];
	logic                   zero_s6 [QW+1];
	logic [2:0]             ng_s6   [QW+1];
	logic [SIDE_W-1:0]      side_s6 [QW+1];
	logic [ROOT_W-1:0]      len_s6  [QW+1];
	logic [2:0][ROOT_W-1:0] drem_s6 [QW+1];
	logic [2:0][QW-1:0]     dbit_s6 [QW+1];
	logic [2:0][QW-1:0]     quo_s6  [QW+1];

	logic [2:0][NUM_W-1:0] num_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = (NUM_W'(s_s5[SQ_N][i]) << FRAC_BITS)
				+ NUM_W'(root_s5[SQ_N] >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6[0] <= 1'b0;
		end else if (en) begin
			vld_s6[0] <= vld_s5[SQ_N];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				drem_s6[0][i] <= ROOT_W'(num_c[i] >> QW);
				dbit_s6[0][i] <= num_c[i][QW-1:0];
			end
			quo_s6[0]  <= '0;
			len_s6[0]  <= root_s5[SQ_N];
			ng_s6[0]   <= ng_s5[SQ_N];
			zero_s6[0] <= zero_s5[SQ_N];
			side_s6[0] <= side_s5[SQ_N];
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		logic [2:0][ROOT_W:0] r2_c;
		logic [ROOT_W:0]      dv_c;
		always_comb begin
			dv_c = {1'b0, len_s6[j-1]};
			for (int i = 0; i < 3; i++) begin
				r2_c[i] = {drem_s6[j-1][i], dbit_s6[j-1][i][QW-1]};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s6[j] <= 1'b0;
			end else if (en) begin
				vld_s6[j] <= vld_s6[j-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (r2_c[i] >= dv_c) begin
						drem_s6[j][i] <= ROOT_W'(r2_c[i] - dv_c);
						quo_s6[j][i]  <= {quo_s6[j-1][i][QW-2:0], 1'b1};
					end else begin
						drem_s6[j][i] <= ROOT_W'(r2_c[i]);
						quo_s6[j][i]  <= {quo_s6[j-1][i][QW-2:0], 1'b0};
					end
					dbit_s6[j][i] <= dbit_s6[j-1][i] << 1;
				end
				len_s6[j]  <= len_s6[j-1];
				ng_s6[j]   <= ng_s6[j-1];
				zero_s6[j] <= zero_s6[j-1];
				side_s6[j] <= side_s6[j-1];
			end
		end
	end

	// stage 7: sign and zero vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s6[QW];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_s6[QW]) begin
					out_vec[i] <= '0;
				end else if (ng_s6[QW][i]) begin
					out_vec[i] <= -COMP_W'(quo_s6[QW][i]);
				end else begin
					out_vec[i] <= COMP_W'(quo_s6[QW][i]);
				end
			end
			out_side <= side_s6[QW];
		end
	end

endmodule

@@ rtl/billboard_matrix.sv @@
// Data are signed fixed point, Q16.16 at the default FRAC_BITS.
// Throughput: one request per cycle when not stalled; each normalisation spends one
// stage per root bit and one per quotient bit, so the depth follows from those two chains.
// The whole pipeline stalls only when the output register and its skid stage are full.
// Reset: asynchronous, active low; clears all valid bits and loads thr_q with 7.
// ----------------------------------------------------------------------------
// billboard_matrix
// Billboard transform: look, right and true up axes plus translation per object.
// ----------------------------------------------------------------------------
module billboard_matrix
	import bbm_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// pos_x, pos_y, pos_z, cam_x, cam_y, cam_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z
	input  logic [ITEM_W-1:0] s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// right_x/y/z, true_up_x/y/z, look_x/y/z, org_x/y/z
	output logic [ITEM_W-1:0] m_tdata,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [THR_W-1:0]  cfg_data
);

	localparam int D_W   = COMP_W + 1;
	localparam int P_W   = 2 * COMP_W;
	localparam int C_W   = P_W + 1;
	localparam int LIM_W = 21;
	localparam int SS_W  = 2 * LIM_W;
	localparam int CMP_W = 48;
	localparam int S1_W  = 1 + 3 * VEC_W;
	localparam int S2_W  = 2 * VEC_W;
	localparam logic [COMP_W-1:0] MIN_C = {1'b1, {(COMP_W-1){1'b0}}};
	localparam logic [COMP_W-1:0] MAX_C = {1'b0, {(COMP_W-1){1'b1}}};

	function automatic logic [P_W-1:0] smul(input logic [COMP_W-1:0] a,
		input logic [COMP_W-1:0] b);
		logic signed [P_W-1:0] r;
		r = P_W'($signed(a)) * P_W'($signed(b));
		return r;
	endfunction

	logic            en;
	logic            skid_full_q;
	logic [THR_W-1:0] thr_q;

	assign en        = !skid_full_q;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	trip_t in_pos, in_cam, in_up, in_fwd;
	assign in_pos = s_tdata[0 +: VEC_W];
	assign in_cam = s_tdata[VEC_W +: VEC_W];
	assign in_up  = s_tdata[2*VEC_W +: VEC_W];
	assign in_fwd = s_tdata[3*VEC_W +: VEC_W];

	// stage 1: offset from camera to object
	logic                vld_s1;
	logic [2:0][D_W-1:0] d_s1;
	trip_t               pos_s1, up_s1, fwd_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {in_pos[i][COMP_W-1], in_pos[i]} - {in_cam[i][COMP_W-1], in_cam[i]};
			end
			pos_s1 <= in_pos;
			up_s1  <= in_up;
			fwd_s1 <= in_fwd;
		end
	end

	// stage 2: near test squares, negated forward vector
	logic [2:0][D_W-1:0] md_c;
	logic                lim_c;
	always_comb begin
		lim_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			md_c[i] = d_s1[i][D_W-1] ? (~d_s1[i] + 1'b1) : d_s1[i];
			if (md_c[i][D_W-1:LIM_W] != '0) lim_c = 1'b0;
		end
	end

	logic                 vld_s2, lim_s2;
	logic [2:0][SS_W-1:0] sq_s2;
	logic [2:0][D_W-1:0]  d_s2;
	trip_t                pos_s2, up_s2, nlook_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]    <= SS_W'(md_c[i][LIM_W-1:0]) * SS_W'(md_c[i][LIM_W-1:0]);
				nlook_s2[i] <= (fwd_s1[i] == MIN_C) ? MAX_C : -fwd_s1[i];
			end
			lim_s2 <= lim_c;
			d_s2   <= d_s1;
			pos_s2 <= pos_s1;
			up_s2  <= up_s1;
		end
	end

	// stage 3: compare squared distance with the threshold
	logic                vld_s3, near_s3;
	logic [2:0][D_W-1:0] d_s3;
	trip_t               pos_s3, up_s3, nlook_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			near_s3  <= lim_s2 && ((CMP_W'(sq_s2[0]) + CMP_W'(sq_s2[1]) + CMP_W'(sq_s2[2]))
				< (CMP_W'(thr_q) << FRAC_BITS));
			d_s3     <= d_s2;
			pos_s3   <= pos_s2;
			up_s3    <= up_s2;
			nlook_s3 <= nlook_s2;
		end
	end

	// look axis normalisation
	logic            n1_vld;
	trip_t           n1_vec;
	logic [S1_W-1:0] n1_side;
	bbm_norm #(
		.IN_W      (D_W),
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (S1_W)
	) u_norm_look (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_vec   (d_s3),
		.in_side  ({near_s3, nlook_s3, pos_s3, up_s3}),
		.out_vld  (n1_vld),
		.out_vec  (n1_vec),
		.out_side (n1_side)
	);

	// stage 4: pick the look axis
	logic  vld_s4;
	trip_t look_s4, pos_s4, up_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= n1_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			look_s4 <= n1_side[S1_W-1] ? n1_side[2*VEC_W +: VEC_W] : n1_vec;
			pos_s4  <= n1_side[VEC_W +: VEC_W];
			up_s4   <= n1_side[0 +: VEC_W];
		end
	end

	// stage 5: products of up x look
	logic                vld_s5;
	logic [5:0][P_W-1:0] pr_s5;
	trip_t               look_s5, pos_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s5[0] <= smul(up_s4[1], look_s4[2]);
			pr_s5[1] <= smul(up_s4[2], look_s4[1]);
			pr_s5[2] <= smul(up_s4[2], look_s4[0]);
			pr_s5[3] <= smul(up_s4[0], look_s4[2]);
			pr_s5[4] <= smul(up_s4[0], look_s4[1]);
			pr_s5[5] <= smul(up_s4[1], look_s4[0]);
			look_s5  <= look_s4;
			pos_s5   <= pos_s4;
		end
	end

	// stage 6: cross components
	logic                vld_s6;
	logic [2:0][C_W-1:0] cr_s6;
	trip_t               look_s6, pos_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cr_s6[i] <= {pr_s5[2*i][P_W-1], pr_s5[2*i]}
					- {pr_s5[2*i+1][P_W-1], pr_s5[2*i+1]};
			end
			look_s6 <= look_s5;
			pos_s6  <= pos_s5;
		end
	end

	// right axis normalisation
	logic            n2_vld;
	trip_t           n2_vec;
	logic [S2_W-1:0] n2_side;
	bbm_norm #(
		.IN_W      (C_W),
		.FRAC_BITS (FRAC_BITS),
		.SIDE_W    (S2_W)
	) u_norm_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s6),
		.in_vec   (cr_s6),
		.in_side  ({look_s6, pos_s6}),
		.out_vld  (n2_vld),
		.out_vec  (n2_vec),
		.out_side (n2_side)
	);

	trip_t look_c;
	assign look_c = n2_side[VEC_W +: VEC_W];

	// stage 7: products of look x right
	logic                vld_s7;
	logic [5:0][P_W-1:0] pr_s7;
	trip_t               right_s7, look_s7, pos_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= n2_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s7[0] <= smul(look_c[1], n2_vec[2]);
			pr_s7[1] <= smul(look_c[2], n2_vec[1]);
			pr_s7[2] <= smul(look_c[2], n2_vec[0]);
			pr_s7[3] <= smul(look_c[0], n2_vec[2]);
			pr_s7[4] <= smul(look_c[0], n2_vec[1]);
			pr_s7[5] <= smul(look_c[1], n2_vec[0]);
			right_s7 <= n2_vec;
			look_s7  <= look_c;
			pos_s7   <= n2_side[0 +: VEC_W];
		end
	end

	// stage 8: true up cross components
	logic                vld_s8;
	logic [2:0][C_W-1:0] tu_s8;
	trip_t               right_s8, look_s8, pos_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				tu_s8[i] <= {pr_s7[2*i][P_W-1], pr_s7[2*i]}
					- {pr_s7[2*i+1][P_W-1], pr_s7[2*i+1]};
			end
			right_s8 <= right_s7;
			look_s8  <= look_s7;
			pos_s8   <= pos_s7;
		end
	end

	// stage 9: drop fraction bits, round half away from zero on the magnitude
	logic [2:0][C_W-1:0] mt_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mt_c[i] = tu_s8[i][C_W-1] ? (~tu_s8[i] + 1'b1) : tu_s8[i];
		end
	end

	logic                vld_s9;
	logic [2:0]          ng_s9;
	logic [2:0][C_W-1:0] rq_s9;
	trip_t               right_s9, look_s9, pos_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ng_s9[i] <= tu_s8[i][C_W-1];
				rq_s9[i] <= C_W'(((C_W+1)'(mt_c[i]) + ((C_W+1)'(1) << (FRAC_BITS - 1)))
					>> FRAC_BITS);
			end
			right_s9 <= right_s8;
			look_s9  <= look_s8;
			pos_s9   <= pos_s8;
		end
	end

	// stage 10: sign and saturation, assemble the result
	logic              vld_s10;
	logic [ITEM_W-1:0] res_s10;
	trip_t             tu_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (ng_s9[i]) begin
				tu_c[i] = (rq_s9[i] >= C_W'(MIN_C)) ? MIN_C : -COMP_W'(rq_s9[i]);
			end else begin
				tu_c[i] = (rq_s9[i] > C_W'(MAX_C)) ? MAX_C : COMP_W'(rq_s9[i]);
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			res_s10 <= {pos_s9, look_s9, tu_c, right_s9};
		end
	end

	// output register with skid stage
	logic              out_vld_q;
	logic [ITEM_W-1:0] out_q, skid_q;
	logic              push, take;
	assign push = en && vld_s10;
	assign take = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (take) skid_full_q <= 1'b0;
		end else if (push) begin
			if (out_vld_q && !take) skid_full_q <= 1'b1;
			out_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take) out_q <= skid_q;
		end else if (push) begin
			if (out_vld_q && !take) skid_q <= res_s10;
			else                    out_q  <= res_s10;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

@@ rtl/bbm_checker.sv @@
// ----------------------------------------------------------------------------
// bbm_checker
// Port level checks on the billboard matrix output stream.
// ----------------------------------------------------------------------------
module bbm_checker
	import bbm_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [ITEM_W-1:0] m_tdata,
	input logic              cfg_valid,
	input logic              cfg_ready
);

	localparam logic signed [COMP_W-1:0] ONE_C = COMP_W'(1) << FRAC_BITS;

	trip_t right_c, tu_c;
	assign right_c = m_tdata[0 +: VEC_W];
	assign tu_c    = m_tdata[VEC_W +: VEC_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input only blocks after the output has been stalled with a result waiting
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && $past(m_tvalid && !m_tready))
		else $error("input blocked without output back-pressure");

	// a zero right axis gives a zero true up axis
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && right_c == '0 |-> tu_c == '0)
		else $error("true up not zero for zero right axis");

	// right axis components stay within unit length
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(right_c[0]) <= ONE_C && $signed(right_c[0]) >= -ONE_C
			&& $signed(right_c[1]) <= ONE_C && $signed(right_c[1]) >= -ONE_C
			&& $signed(right_c[2]) <= ONE_C && $signed(right_c[2]) >= -ONE_C)
		else $error("right axis component beyond unit");

	// config writes are never refused
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind billboard_matrix bbm_checker #(.FRAC_BITS(FRAC_BITS)) u_bbm_checker (.*);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for billboard_matrix: streams object and camera requests
// through the pipeline with random gaps and output stalls, predicts every
// axis in software at the block's widths and compares each result field.
// ----------------------------------------------------------------------------
module tb_top;
	import bbm_pkg::*;

	localparam int FRAC        = 16;
	localparam int LATENCY     = 89 + 2 * FRAC;
	localparam int WDOG_LIMIT  = 4000;
	localparam int N_RANDOM    = 1000;

	typedef longint signed vec_t [3];

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [ITEM_W-1:0] s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [ITEM_W-1:0] m_tdata;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [THR_W-1:0]  cfg_data;

	logic [THR_W-1:0]  thr_shadow;
	logic [ITEM_W-1:0] axes_expected [$];
	int                fail_count;
	int                sent_count;
	int                recv_count;
	int                idle_cycles;
	bit                no_gaps;

	billboard_matrix #(.FRAC_BITS(FRAC)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// axis predictor
	// ------------------------------------------------------------------
	function automatic longint unsigned mag64(longint signed v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint signed clamp32(longint signed v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic vec_t cross_vec(vec_t a, vec_t b);
		vec_t r;
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
		return r;
	endfunction

	function automatic vec_t unit_vec(vec_t v);
		longint unsigned m [3];
		longint unsigned mx;
		longint unsigned len;
		longint unsigned q;
		vec_t r;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag64(v[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			r[0] = 0; r[1] = 0; r[2] = 0;
			return r;
		end
		// bring the largest magnitude to the top window
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
			mx = mx >> 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
			mx = mx << 1;
		end
		len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FRAC) + (len >> 1)) / len;
			r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return r;
	endfunction

	function automatic longint signed descale_round(longint signed v);
		longint unsigned q;
		q = (mag64(v) + (64'd1 << (FRAC - 1))) >> FRAC;
		return clamp32(v < 0 ? -longint'(q) : longint'(q));
	endfunction

	function automatic logic [ITEM_W-1:0] predict_axes(logic [ITEM_W-1:0] req,
			logic [THR_W-1:0] thr);
		longint signed   f [12];
		longint signed   res [12];
		vec_t            d, up, look, right, tu;
		longint unsigned lim, s;
		bit              is_near;
		logic [ITEM_W-1:0] out;
		for (int i = 0; i < 12; i++)
			f[i] = longint'($signed(req[COMP_W*i +: COMP_W]));
		for (int i = 0; i < 3; i++) begin
			d[i]  = f[i] - f[3+i];
			up[i] = f[6+i];
		end
		lim = 64'd1 << 21;
		is_near = 1'b0;
		if (mag64(d[0]) < lim && mag64(d[1]) < lim && mag64(d[2]) < lim) begin
			s = mag64(d[0]) * mag64(d[0]) + mag64(d[1]) * mag64(d[1])
				+ mag64(d[2]) * mag64(d[2]);
			is_near = s < (64'(thr) << FRAC);
		end
		// near objects face along the negated camera forward
		if (is_near) begin
			for (int i = 0; i < 3; i++) look[i] = clamp32(-f[9+i]);
		end else begin
			look = unit_vec(d);
		end
		right = unit_vec(cross_vec(up, look));
		tu    = cross_vec(look, right);
		for (int i = 0; i < 3; i++) begin
			res[i]   = right[i];
			res[3+i] = descale_round(tu[i]);
			res[6+i] = look[i];
			res[9+i] = f[i];
		end
		for (int i = 0; i < 12; i++) out[COMP_W*i +: COMP_W] = res[i][COMP_W-1:0];
		return out;
	endfunction

	// ------------------------------------------------------------------
	// request driver and register writes
	// ------------------------------------------------------------------
	task automatic send_item(logic [ITEM_W-1:0] req);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= req;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		axes_expected.push_back(predict_axes(req, thr_shadow));
		sent_count++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (axes_expected.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid  <= 1'b0;
		thr_shadow = val;
	endtask

	function automatic logic [ITEM_W-1:0] pack_req(logic [31:0] p [12]);
		logic [ITEM_W-1:0] r;
		for (int i = 0; i < 12; i++) r[COMP_W*i +: COMP_W] = p[i];
		return r;
	endfunction

	// object near the camera, offsets straddling the threshold
	function automatic logic [ITEM_W-1:0] near_req();
		logic [31:0] p [12];
		int span;
		span = ($urandom_range(0, 3) == 0) ? 2200000 : 70000;
		for (int i = 0; i < 12; i++) p[i] = $urandom;
		for (int i = 0; i < 3; i++)
			p[i] = p[3+i] + 32'($signed($urandom_range(0, 2 * span)) - span);
		return pack_req(p);
	endfunction

	function automatic logic [ITEM_W-1:0] scene_req();
		logic [31:0] p [12];
		for (int i = 0; i < 12; i++) p[i] = 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
		// sometimes the up vector runs along the view direction
		if ($urandom_range(0, 7) == 0) begin
			for (int i = 0; i < 3; i++) p[6+i] = (p[i] - p[3+i]) >>> 2;
		end
		return pack_req(p);
	endfunction

	function automatic logic [ITEM_W-1:0] noise_req();
		logic [31:0] p [12];
		for (int i = 0; i < 12; i++) p[i] = $urandom;
		return pack_req(p);
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		logic [31:0] p [12];
		logic [31:0] xt [4];
		xt[0] = 32'h8000_0000; xt[1] = 32'h7FFF_FFFF; xt[2] = 32'h0; xt[3] = 32'hFFFF_FFFF;
		// plain view along z with y up
		foreach (p[i]) p[i] = 0;
		p[2] = 32'h000A_0000; p[7] = 32'h0001_0000; p[11] = 32'h0001_0000;
		send_item(pack_req(p));
		// near, with the forward at the negative extreme
		foreach (p[i]) p[i] = 0;
		p[7] = 32'h0001_0000; p[9] = 32'h8000_0000; p[10] = 32'h7FFF_FFFF;
		p[11] = 32'h8000_0000;
		send_item(pack_req(p));
		// up parallel to the view: degenerate cross
		foreach (p[i]) p[i] = 0;
		p[1] = 32'h0010_0000; p[7] = 32'h0001_0000;
		send_item(pack_req(p));
		// zero up vector
		foreach (p[i]) p[i] = 0;
		p[0] = 32'h0100_0000;
		send_item(pack_req(p));
		// extreme corners of every field
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 12; i++) p[i] = xt[(i + k) % 4];
			send_item(pack_req(p));
		end
		// object and camera at opposite extremes
		for (int i = 0; i < 3; i++) begin
			p[i] = 32'h7FFF_FFFF; p[3+i] = 32'h8000_0000;
			p[6+i] = 32'h8000_0000; p[9+i] = 32'h7FFF_FFFF;
		end
		send_item(pack_req(p));
		// zero distance: near under the reset threshold
		foreach (p[i]) p[i] = 32'h1234_5678;
		p[6] = 32'h0001_0000;
		send_item(pack_req(p));
	endtask

	task automatic test_threshold_settings();
		logic [31:0] p [12];
		// zero threshold: zero distance normalises a zero vector
		write_threshold('0);
		foreach (p[i]) p[i] = 32'h0003_0000;
		p[7] = 32'h0001_0000;
		send_item(pack_req(p));
		for (int n = 0; n < 20; n++) send_item(near_req());
		write_threshold(17'd65536);
		send_item(pack_req(p));
		for (int n = 0; n < 20; n++) send_item(near_req());
	endtask

	task automatic test_random_stream();
		logic [THR_W-1:0] settings [4];
		int pick;
		settings[0] = THR_RESET; settings[1] = 17'd65536;
		settings[2] = 17'd0;     settings[3] = 17'($urandom_range(0, 65536));
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 4) write_threshold(17'h1_FFFF & 17'($urandom_range(0, 65536)));
			else write_threshold(settings[ph]);
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				// bursts without gaps every so often
				if (n % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
				pick = $urandom_range(0, 9);
				if (pick < 4) send_item(near_req());
				else if (pick < 8) send_item(scene_req());
				else send_item(noise_req());
				// hold the stream until the pipeline has emptied
				if (n == 100) begin
					s_tvalid <= 1'b0;
					while (axes_expected.size() != 0) @(posedge clk);
				end
			end
			no_gaps = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// result consumer and checker
	// ------------------------------------------------------------------
	initial begin
		int stall;
		logic [ITEM_W-1:0] got;
		logic [ITEM_W-1:0] want;
		string names [12];
		names = '{"right_x", "right_y", "right_z", "true_up_x", "true_up_y",
			"true_up_z", "look_x", "look_y", "look_z", "org_x", "org_y", "org_z"};
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
			while (!m_tvalid) @(negedge clk);
			got = m_tdata;
			@(posedge clk);
			recv_count++;
			if (axes_expected.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				fail_count++;
			end else begin
				want = axes_expected.pop_front();
				for (int i = 0; i < 12; i++)
					if (got[COMP_W*i +: COMP_W] !== want[COMP_W*i +: COMP_W]) begin
						$display("%0t: %s expected %h actual %h", $time, names[i],
							want[COMP_W*i +: COMP_W], got[COMP_W*i +: COMP_W]);
						fail_count++;
					end
			end
		end
	end

	// watchdog on cycles with no accepted transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				axes_expected.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// sequence
	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		thr_shadow  = THR_RESET;
		fail_count  = 0;
		sent_count  = 0;
		recv_count  = 0;
		idle_cycles = 0;
		no_gaps     = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold_settings();
		test_random_stream();
		wait_drained();
		$display("covered %0d requests and %0d results over thresholds 0, 7, 65536 and random,",
			sent_count, recv_count);
		$display("with near, far, degenerate and extreme-value objects under random stalls");
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
